### sv/artl_pkg.sv
// Shared types and constants for the address range table lookup.
`timescale 1ns / 1ps

package artl_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;

  localparam int ADDR_W      = 64;
  localparam int OFFSET_W    = 31;
  localparam int HIT_INDEX_W = 10;
  localparam int COUNT_OUT_W = 11;
  localparam int FUNC_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int ENTRY_W     = ADDR_W + OFFSET_W;

  localparam int IN_TDATA_W  = 160;
  localparam int OUT_TDATA_W = 56;

  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 64;
  localparam logic REG_PC_BASE = 1'b0;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_LOOKUP = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_BELOW_BASE = 2'd2,
    ST_NO_ENTRY   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_FETCH,
    S_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } probe_ctl_t;

endpackage

### sv/artl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module artl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/artl_probe.sv
// Binary search bounds and the shared 64-bit compare used on every probe.
`timescale 1ns / 1ps

module artl_probe #(
  parameter int TABLE_DEPTH = artl_pkg::DEF_TABLE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  artl_pkg::probe_ctl_t                ctl,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]    load_count,
  input  logic [artl_pkg::ADDR_W-1:0]         load_key,
  input  logic [artl_pkg::ADDR_W-1:0]         rd_addr,
  output logic                                active,
  output logic [$clog2(TABLE_DEPTH)-1:0]      mid,
  output logic                                lo_zero,
  output logic [$clog2(TABLE_DEPTH)-1:0]      lo_m1
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = $clog2(TABLE_DEPTH);

  logic [CW-1:0]               lo_r, lo_nxt;
  logic [CW-1:0]               hi_r, hi_nxt;
  logic [artl_pkg::ADDR_W-1:0] key_r, key_nxt;
  logic [CW-1:0]               mid_full;
  logic [CW-1:0]               lo_m1_full;

  assign mid_full   = lo_r + ((hi_r - lo_r) >> 1);
  assign lo_m1_full = lo_r - CW'(1);
  assign mid        = mid_full[IW-1:0];
  assign lo_m1      = lo_m1_full[IW-1:0];
  assign active     = (lo_r < hi_r);
  assign lo_zero    = (lo_r == '0);

  always_comb begin
    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    key_nxt = key_r;
    if (ctl.load) begin
      lo_nxt  = '0;
      hi_nxt  = load_count;
      key_nxt = load_key;
    end else if (ctl.step) begin
      // advance the lower bound past a probe at or below the key
      if (rd_addr <= key_r) begin
        lo_nxt = mid_full + CW'(1);
      end else begin
        hi_nxt = mid_full;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r <= '0;
      hi_r <= '0;
    end else begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
    key_r <= key_nxt;
  end

endmodule

### sv/address_range_table_lookup.sv
// Top level of the address range table lookup: control sequencer, table and result register.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_*): one transfer per operation. in_tuser carries the
//   operation (clear, append, lookup); in_tdata carries the entry address,
//   entry offset and runtime counter. Result channel (out_*): exactly one
//   transfer per operation, status in out_tuser, index, offset and count in
//   out_tdata. Configuration (cfg_*): APB-style, counter base at byte address 0.
// Sequence:
//   Clear, append, unused codes and counters below the base: no search; the
//   result goes to the output register and the next transfer is taken once
//   it is loaded. Lookup: each probe is one registered table read and one
//   compare in the shared comparator, up to ceil(log2(count+1)) probes,
//   then a closing step, a fetch of the hit entry and the result step; the
//   fetch is skipped when no entry is found. in_tready is high only while
//   the sequencer is idle.
// Reset clears the entry count, the counter base and the output valid flag;
// the table contents are left as they are. When the receiver stalls, the
// result holds in the output register and the next operation may still be
// taken; its result waits until the register drains.

module address_range_table_lookup #(
  parameter int TABLE_DEPTH = artl_pkg::DEF_TABLE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [63:0] entry_address, [94:64] entry_offset, [158:95] runtime_counter
  input  logic [artl_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [1:0] func
  input  logic [artl_pkg::FUNC_W-1:0]         in_tuser,
  // result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [9:0] hit_index, [40:10] hit_offset, [51:41] entry_count
  output logic [artl_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [1:0] status
  output logic [artl_pkg::STATUS_W-1:0]       out_tuser,
  // configuration port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [artl_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [artl_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [artl_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int AW = artl_pkg::ADDR_W;
  localparam int OW = artl_pkg::OFFSET_W;

  // Input fields
  logic [AW-1:0]     f_entry_address;
  logic [OW-1:0]     f_entry_offset;
  logic [AW-1:0]     f_runtime_counter;
  artl_pkg::func_t   f_func;

  assign f_entry_address   = in_tdata[AW-1:0];
  assign f_entry_offset    = in_tdata[AW+OW-1:AW];
  assign f_runtime_counter = in_tdata[2*AW+OW-1:AW+OW];
  assign f_func            = artl_pkg::func_t'(in_tuser);

  // Configuration register
  logic [AW-1:0] pc_base_r, pc_base_nxt;
  logic          cfg_write;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[3] == artl_pkg::REG_PC_BASE) ? pc_base_r : '0;

  always_comb begin
    pc_base_nxt = pc_base_r;
    if (cfg_write && (cfg_paddr[3] == artl_pkg::REG_PC_BASE)) begin
      pc_base_nxt = cfg_pwdata;
    end
  end

  // Sequencer state and result
  artl_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  artl_pkg::status_t res_status_r, res_status_nxt;
  logic [IW-1:0]     res_index_r, res_index_nxt;
  logic [OW-1:0]     res_offset_r, res_offset_nxt;

  logic                                out_tvalid_r, out_tvalid_nxt;
  logic [artl_pkg::OUT_TDATA_W-1:0]    out_tdata_r, out_tdata_nxt;
  logic [artl_pkg::STATUS_W-1:0]       out_tuser_r, out_tuser_nxt;

  logic          in_fire;
  logic          table_full;
  logic [AW:0]   rebased;
  logic          below_base;
  logic          load_out;

  // Table memory and search unit
  logic                           ram_we;
  logic                           ram_re;
  logic [IW-1:0]                  ram_raddr;
  logic [artl_pkg::ENTRY_W-1:0]   ram_wdata;
  logic [artl_pkg::ENTRY_W-1:0]   ram_rdata;
  artl_pkg::probe_ctl_t           probe_ctl;
  logic                           probe_active;
  logic [IW-1:0]                  probe_mid;
  logic                           probe_lo_zero;
  logic [IW-1:0]                  probe_lo_m1;

  // Width adaption of the result fields
  logic [CW+artl_pkg::COUNT_OUT_W-1:0] count_wide;
  logic [IW+artl_pkg::HIT_INDEX_W-1:0] index_wide;

  assign in_tready  = (state_r == artl_pkg::S_IDLE);
  assign in_fire    = in_tvalid & in_tready;
  assign table_full = (count_r >= CW'(TABLE_DEPTH));
  assign rebased    = {1'b0, f_runtime_counter} - {1'b0, pc_base_r};
  assign below_base = rebased[AW];
  assign ram_wdata  = {f_entry_offset, f_entry_address};
  assign ram_we     = in_fire && (f_func == artl_pkg::FUNC_APPEND) && !table_full;
  assign ram_re     = (state_r == artl_pkg::S_PROBE);
  // probe the midpoint while the range is open, else fetch the hit entry
  assign ram_raddr  = probe_active ? probe_mid : probe_lo_m1;

  assign probe_ctl.load = in_fire && (f_func == artl_pkg::FUNC_LOOKUP) && !below_base;
  assign probe_ctl.step = (state_r == artl_pkg::S_CMP);

  assign count_wide = {{artl_pkg::COUNT_OUT_W{1'b0}}, count_r};
  assign index_wide = {{artl_pkg::HIT_INDEX_W{1'b0}}, res_index_r};
  assign load_out   = (state_r == artl_pkg::S_RESP) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_index_nxt  = res_index_r;
    res_offset_nxt = res_offset_r;
    case (state_r)
      artl_pkg::S_IDLE: begin
        if (in_fire) begin
          res_status_nxt = artl_pkg::ST_OK;
          res_index_nxt  = '0;
          res_offset_nxt = '0;
          state_nxt      = artl_pkg::S_RESP;
          case (f_func)
            artl_pkg::FUNC_CLEAR: begin
              count_nxt = '0;
            end
            artl_pkg::FUNC_APPEND: begin
              if (table_full) begin
                res_status_nxt = artl_pkg::ST_FULL;
              end else begin
                count_nxt = count_r + CW'(1);
              end
            end
            artl_pkg::FUNC_LOOKUP: begin
              if (below_base) begin
                res_status_nxt = artl_pkg::ST_BELOW_BASE;
              end else begin
                state_nxt = artl_pkg::S_PROBE;
              end
            end
            default: begin
              // unused code: state unchanged, plain ok result
            end
          endcase
        end
      end
      artl_pkg::S_PROBE: begin
        if (probe_active) begin
          state_nxt = artl_pkg::S_CMP;
        end else if (probe_lo_zero) begin
          res_status_nxt = artl_pkg::ST_NO_ENTRY;
          state_nxt      = artl_pkg::S_RESP;
        end else begin
          state_nxt = artl_pkg::S_FETCH;
        end
      end
      artl_pkg::S_CMP: begin
        state_nxt = artl_pkg::S_PROBE;
      end
      artl_pkg::S_FETCH: begin
        res_status_nxt = artl_pkg::ST_OK;
        res_index_nxt  = probe_lo_m1;
        res_offset_nxt = ram_rdata[artl_pkg::ENTRY_W-1:AW];
        state_nxt      = artl_pkg::S_RESP;
      end
      artl_pkg::S_RESP: begin
        if (load_out) begin
          state_nxt = artl_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = artl_pkg::S_IDLE;
      end
    endcase
  end

  // Output register: hold while stalled, refill once drained
  always_comb begin
    out_tvalid_nxt = out_tvalid_r & ~out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    if (load_out) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {4'b0,
                        count_wide[artl_pkg::COUNT_OUT_W-1:0],
                        res_offset_r,
                        index_wide[artl_pkg::HIT_INDEX_W-1:0]};
      out_tuser_nxt  = res_status_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= artl_pkg::S_IDLE;
      count_r      <= '0;
      pc_base_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      pc_base_r    <= pc_base_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    res_status_r <= res_status_nxt;
    res_index_r  <= res_index_nxt;
    res_offset_r <= res_offset_nxt;
    out_tdata_r  <= out_tdata_nxt;
    out_tuser_r  <= out_tuser_nxt;
  end

  artl_ram #(
    .WIDTH (artl_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IW-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  artl_probe #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_probe (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (probe_ctl),
    .load_count (count_r),
    .load_key   (rebased[AW-1:0]),
    .rd_addr    (ram_rdata[AW-1:0]),
    .active     (probe_active),
    .mid        (probe_mid),
    .lo_zero    (probe_lo_zero),
    .lo_m1      (probe_lo_m1)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (f_func == artl_pkg::FUNC_CLEAR)) |=> (count_r == '0))
    else $error("clear did not empty the table");

  a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == artl_pkg::S_CMP) |-> probe_active)
    else $error("compare step with an empty search range");

  a_no_write_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == artl_pkg::S_IDLE))
    else $error("table written during a search");
`endif

endmodule

### bench/testbench.sv
// Self-checking testbench for the address range table lookup block.
`timescale 1ns / 1ps

module testbench;

  localparam int TABLE_DEPTH = artl_pkg::DEF_TABLE_DEPTH;
  localparam logic [artl_pkg::CFG_ADDR_W-1:0] PC_BASE_ADDR =
    artl_pkg::CFG_ADDR_W'(8 * int'(artl_pkg::REG_PC_BASE));
  localparam logic [63:0] ADDR_MAX = '1;
  localparam logic [30:0] OFF_MAX = '1;
  // receiver hold-off used to back the block up into its input
  localparam int unsigned HOLD_CYCLES = 300;
  // idle wait after the last reply, longer than a full-depth lookup takes
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_PRINTED = 100;

  // one result transfer: the out_tuser status and the out_tdata fields
  typedef struct packed {
    artl_pkg::status_t status;
    logic [9:0]        index;
    logic [30:0]       offset;
    logic [10:0]       count;
  } table_reply_t;

  // one row of the directed part; set_base reprograms the counter base first
  typedef struct {
    bit              set_base;
    logic [63:0]     base;
    artl_pkg::func_t func;
    logic [63:0]     entry_addr;
    logic [30:0]     entry_off;
    logic [63:0]     counter;
    bit              typed;
    table_reply_t    reply;
  } stim_row_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  // [63:0] entry_address, [94:64] entry_offset, [158:95] runtime_counter, [159] zero
  logic [artl_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  // [1:0] func
  logic [artl_pkg::FUNC_W-1:0]      in_tuser = artl_pkg::FUNC_NOP;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  // [9:0] hit_index, [40:10] hit_offset, [51:41] entry_count, [55:52] zero
  logic [artl_pkg::OUT_TDATA_W-1:0] out_tdata;
  // [1:0] status
  logic [artl_pkg::STATUS_W-1:0]    out_tuser;
  logic                             cfg_psel = 1'b0;
  logic                             cfg_penable = 1'b0;
  logic                             cfg_pwrite = 1'b0;
  logic [artl_pkg::CFG_ADDR_W-1:0]  cfg_paddr = '0;
  logic [artl_pkg::CFG_DATA_W-1:0]  cfg_pwdata = '0;
  logic [artl_pkg::CFG_DATA_W-1:0]  cfg_prdata;
  logic                             cfg_pready;

  // mirror of the block's table and register
  logic [63:0]  tbl_addr [TABLE_DEPTH];
  logic [30:0]  tbl_off  [TABLE_DEPTH];
  int unsigned  tbl_count = 0;
  logic [63:0]  pc_base_cfg = '0;

  table_reply_t pending_replies[$];
  stim_row_t    directed_rows[$];
  logic [63:0]  seq_starts[$];
  int unsigned  ops_sent = 0;
  int unsigned  mismatches = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  bit           hold_req = 1'b0;
  int unsigned  hold_left = 0;

  address_range_table_lookup #(.TABLE_DEPTH(TABLE_DEPTH)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [30:0] rand31();
    return 31'($urandom);
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (mismatches < MAX_PRINTED)
      $display("[%0t] mismatch in %s: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Apply one operation to the mirror and return the reply it should give.
  // The halving search runs the same way whether or not the entries are sorted,
  // so unordered appends still have one defined answer.
  function automatic table_reply_t apply_table_op(input artl_pkg::func_t f,
                                                  input logic [63:0] ea,
                                                  input logic [30:0] eo,
                                                  input logic [63:0] pc);
    table_reply_t r;
    logic [63:0]  rel;
    int unsigned  lo, hi, mid;
    r.status = artl_pkg::ST_OK;
    r.index  = '0;
    r.offset = '0;
    case (f)
      artl_pkg::FUNC_CLEAR: tbl_count = 0;
      artl_pkg::FUNC_APPEND: begin
        if (tbl_count >= TABLE_DEPTH) begin
          r.status = artl_pkg::ST_FULL;
        end else begin
          tbl_addr[tbl_count] = ea;
          tbl_off[tbl_count]  = eo;
          tbl_count++;
        end
      end
      artl_pkg::FUNC_LOOKUP: begin
        if (pc < pc_base_cfg) begin
          r.status = artl_pkg::ST_BELOW_BASE;
        end else begin
          rel = pc - pc_base_cfg;
          lo  = 0;
          hi  = tbl_count;
          while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (tbl_addr[mid] <= rel) lo = mid + 1;
            else hi = mid;
          end
          if (lo == 0) begin
            r.status = artl_pkg::ST_NO_ENTRY;
          end else begin
            r.index  = 10'(lo - 1);
            r.offset = tbl_off[lo - 1];
          end
        end
      end
      default: ;
    endcase
    r.count = 11'(tbl_count);
    return r;
  endfunction

  // Offer one operation, hold it until the block takes it, then queue its reply.
  task automatic push_op(input artl_pkg::func_t f, input logic [63:0] ea,
                         input logic [30:0] eo, input logic [63:0] pc, input bit typed,
                         input table_reply_t typed_reply);
    table_reply_t predicted;
    int unsigned  gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {1'b0, pc, eo, ea};
    do @(posedge clk); while (!in_tready);
    predicted = apply_table_op(f, ea, eo, pc);
    pending_replies.push_back(typed ? typed_reply : predicted);
    ops_sent++;
  endtask

  // Drop the input valid and wait until every reply is in and the block is quiet.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the counter base while the block is idle, then read it back.
  task automatic program_pc_base(input logic [63:0] value);
    drain_results();
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= PC_BASE_ADDR;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== value) flag_mismatch("pc_base read-back", cfg_prdata, value);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    pc_base_cfg = value;
  endtask

  function automatic void add_directed(input bit set_base, input logic [63:0] base,
                                       input artl_pkg::func_t f, input logic [63:0] ea,
                                       input logic [30:0] eo, input logic [63:0] pc,
                                       input bit typed, input artl_pkg::status_t st,
                                       input logic [9:0] idx, input logic [30:0] off,
                                       input logic [10:0] cnt);
    stim_row_t row;
    row.set_base     = set_base;
    row.base         = base;
    row.func         = f;
    row.entry_addr   = ea;
    row.entry_off    = eo;
    row.counter      = pc;
    row.typed        = typed;
    row.reply.status = st;
    row.reply.index  = idx;
    row.reply.offset = off;
    row.reply.count  = cnt;
    directed_rows.push_back(row);
  endfunction

  // Append k entries in ascending order with a random spread; clamp on wrap,
  // which leaves runs of equal start addresses near the top.
  task automatic append_ascending(input int unsigned k);
    logic [63:0] a, nxt;
    int unsigned sh;
    sh = $urandom_range(0, 63);
    a  = rand64() >> $urandom_range(0, 63);
    for (int unsigned i = 0; i < k; i++) begin
      seq_starts.push_back(a);
      push_op(artl_pkg::FUNC_APPEND, a, rand31(), rand64(), 1'b0, '0);
      nxt = a + (rand64() >> sh);
      a   = (nxt < a) ? a : nxt;
    end
  endtask

  // Pick a counter that lands on, just beside or just below an entry of the
  // current sequence, now and then below the base or anywhere at all.
  function automatic logic [63:0] pick_counter();
    logic [63:0] a;
    if (seq_starts.size() == 0 || $urandom_range(9) == 0) return rand64();
    a = seq_starts[$urandom_range(seq_starts.size() - 1)];
    case ($urandom_range(5))
      0: a = a - 1;
      1: a = a + 1;
      2: a = a + 64'($urandom_range(1, 1000));
      3: return pc_base_cfg - 64'($urandom_range(1, 100));
      default: ;
    endcase
    return a + pc_base_cfg;
  endfunction

  // Random traffic: mostly clear, sorted load and lookups; the rest is loose
  // operations of any code and unordered appends.
  task automatic run_table_traffic(input int unsigned budget);
    int unsigned stop_at, pick, k;
    stop_at = ops_sent + budget;
    while (ops_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        seq_starts.delete();
        push_op(artl_pkg::FUNC_CLEAR, rand64(), rand31(), rand64(), 1'b0, '0);
        k = ($urandom_range(9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
        append_ascending(k);
        repeat ($urandom_range(4, 30))
          push_op(artl_pkg::FUNC_LOOKUP, rand64(), rand31(), pick_counter(), 1'b0, '0);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 5))
          push_op(artl_pkg::func_t'($urandom_range(3)), rand64(), rand31(), rand64(),
                  1'b0, '0);
      end else begin
        repeat ($urandom_range(2, 12)) begin
          seq_starts.push_back(rand64());
          push_op(artl_pkg::FUNC_APPEND, seq_starts[$], rand31(), rand64(), 1'b0, '0);
        end
        repeat ($urandom_range(2, 10))
          push_op(artl_pkg::FUNC_LOOKUP, rand64(), rand31(), pick_counter(), 1'b0, '0);
      end
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare every result transfer with the oldest reply waiting.
  always @(posedge clk) begin
    table_reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_replies.size() == 0) begin
        flag_mismatch("unexpected result", {out_tdata, out_tuser}, '0);
      end else begin
        want = pending_replies.pop_front();
        if (out_tuser !== want.status)       flag_mismatch("status", out_tuser, want.status);
        if (out_tdata[9:0] !== want.index)   flag_mismatch("hit_index", out_tdata[9:0],
                                                           want.index);
        if (out_tdata[40:10] !== want.offset) flag_mismatch("hit_offset", out_tdata[40:10],
                                                            want.offset);
        if (out_tdata[51:41] !== want.count) flag_mismatch("entry_count", out_tdata[51:41],
                                                           want.count);
      end
    end
  end

  initial begin
    // Directed rows: set, base, func, entry address, offset, counter, then the
    // typed reply (status, index, offset, count) where it is obvious.
    // Empty table, unused code with every field high, then three entries
    // reaching the top of the address range.
    add_directed(0, 0, artl_pkg::FUNC_LOOKUP, 0, 0, 0, 1, artl_pkg::ST_NO_ENTRY, 0, 0, 0);
    add_directed(0, 0, artl_pkg::FUNC_NOP, ADDR_MAX, OFF_MAX, ADDR_MAX, 1, artl_pkg::ST_OK,
                 0, 0, 0);
    add_directed(0, 0, artl_pkg::FUNC_APPEND, 'h100, 0, 0, 1, artl_pkg::ST_OK, 0, 0, 1);
    add_directed(0, 0, artl_pkg::FUNC_APPEND, 'h200, OFF_MAX, 0, 1, artl_pkg::ST_OK, 0, 0, 2);
    add_directed(0, 0, artl_pkg::FUNC_APPEND, ADDR_MAX, 'h1234, 0, 1, artl_pkg::ST_OK,
                 0, 0, 3);
    // below the first entry, on and between entries, top of range
    add_directed(0, 0, artl_pkg::FUNC_LOOKUP, 0, 0, 'hff, 1, artl_pkg::ST_NO_ENTRY, 0, 0, 3);
    add_directed(0, 0, artl_pkg::FUNC_LOOKUP, 0, 0, 'h100, 1, artl_pkg::ST_OK, 0, 0, 3);
    add_directed(0, 0, artl_pkg::FUNC_LOOKUP, 0, 0, 'h1ff, 1, artl_pkg::ST_OK, 0, 0, 3);
    add_directed(0, 0, artl_pkg::FUNC_LOOKUP, 0, 0, 'h200, 1, artl_pkg::ST_OK, 1, OFF_MAX, 3);
    add_directed(0, 0, artl_pkg::FUNC_LOOKUP, 0, 0, ADDR_MAX, 1, artl_pkg::ST_OK,
                 2, 'h1234, 3);
    // non-zero base: counter just below it, at it, and above
    add_directed(1, 'h1000, artl_pkg::FUNC_LOOKUP, 0, 0, 'hfff, 1, artl_pkg::ST_BELOW_BASE,
                 0, 0, 3);
    add_directed(0, 0, artl_pkg::FUNC_LOOKUP, 0, 0, 'h1000, 1, artl_pkg::ST_NO_ENTRY,
                 0, 0, 3);
    add_directed(0, 0, artl_pkg::FUNC_LOOKUP, 0, 0, 'h1100, 1, artl_pkg::ST_OK, 0, 0, 3);
    add_directed(0, 0, artl_pkg::FUNC_LOOKUP, 0, 0, ADDR_MAX, 0, artl_pkg::ST_OK, 0, 0, 0);
    // out-of-order append, then a lookup whose halving search misses it
    add_directed(0, 0, artl_pkg::FUNC_APPEND, 'h50, 5, 0, 1, artl_pkg::ST_OK, 0, 0, 4);
    add_directed(0, 0, artl_pkg::FUNC_LOOKUP, 0, 0, 'h1060, 0, artl_pkg::ST_OK, 0, 0, 0);
    add_directed(0, 0, artl_pkg::FUNC_CLEAR, ADDR_MAX, OFF_MAX, ADDR_MAX, 1,
                 artl_pkg::ST_OK, 0, 0, 0);
    add_directed(0, 0, artl_pkg::FUNC_LOOKUP, 0, 0, 'h1100, 1, artl_pkg::ST_NO_ENTRY,
                 0, 0, 0);
    // base at the top of the range
    add_directed(1, ADDR_MAX, artl_pkg::FUNC_LOOKUP, 0, 0, ADDR_MAX - 1, 1,
                 artl_pkg::ST_BELOW_BASE, 0, 0, 0);
    add_directed(0, 0, artl_pkg::FUNC_APPEND, 0, 1, 0, 1, artl_pkg::ST_OK, 0, 0, 1);
    add_directed(0, 0, artl_pkg::FUNC_LOOKUP, 0, 0, ADDR_MAX, 1, artl_pkg::ST_OK, 0, 1, 1);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_base) program_pc_base(directed_rows[i].base);
      push_op(directed_rows[i].func, directed_rows[i].entry_addr, directed_rows[i].entry_off,
              directed_rows[i].counter, directed_rows[i].typed, directed_rows[i].reply);
    end

    // Phase one: sender idles lightly, receiver heavily, random base.
    program_pc_base(rand64());
    send_idle_pct = 18;
    recv_idle_pct = 46;
    run_table_traffic(350);

    // Phase two: the other way round; fill the table to the brim and past it.
    program_pc_base('0);
    send_idle_pct = 46;
    recv_idle_pct = 18;
    seq_starts.delete();
    push_op(artl_pkg::FUNC_CLEAR, rand64(), rand31(), rand64(), 1'b0, '0);
    append_ascending(TABLE_DEPTH);
    repeat (3) push_op(artl_pkg::FUNC_APPEND, rand64(), rand31(), rand64(), 1'b0, '0);
    repeat (40)
      push_op(artl_pkg::FUNC_LOOKUP, rand64(), rand31(), pick_counter(), 1'b0, '0);
    run_table_traffic(100);

    // Phase three: no idling, but hold the receiver off for a long stretch
    // while the sender keeps offering, so the block backs up.
    program_pc_base({1'b0, rand64() >> 1});
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    run_table_traffic(300);

    drain_results();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
